[rtl/mnp_pkg.sv]
`timescale 1ns / 1ps
// Package for the multiset next-permutation engine: field widths, command and
// register codes, reset values and the symbol saturation helper.
// No dependencies.
package mnp_pkg;

    // Field widths
    localparam int SYM_W       = 4;   // normalized symbol
    localparam int POS_W       = 5;   // emitted position
    localparam int SEQ_LEN_W   = 6;   // seq_len register
    localparam int ALPHA_W     = 5;   // alphabet_size register
    localparam int OUT_CAP     = 32;  // longest sequence a run can emit

    // Stream payload widths (byte padded)
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_SEQ_LEN       = 1'b0;
    localparam cfg_idx_t REG_ALPHABET_SIZE = 1'b1;

    // Commands carried on the input tuser bit
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Register reset values
    localparam logic [SEQ_LEN_W-1:0] SEQ_LEN_RST = 6'd2;
    localparam logic [ALPHA_W-1:0]   ALPHA_RST   = 5'd16;

    // Clamp a symbol to the top of the active alphabet
    function automatic logic [SYM_W-1:0] sat_sym(input logic [SYM_W-1:0] s,
                                                 input logic [ALPHA_W-1:0] a);
        logic [SYM_W-1:0] r;
        if (ALPHA_W'(s) >= a)
            r = SYM_W'(a - 1'b1);
        else
            r = s;
        return r;
    endfunction

endpackage

[rtl/mnp_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds until the next read enable. No dependencies.
module mnp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage array and read register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/multiset_next_permutation_top.sv]
`timescale 1ns / 1ps
// Top level of the multiset next-permutation engine: command decode, sequencer
// and output register. Depends on mnp_pkg and mnp_ram.
//
//  channel   signals                         direction  contents
//  s_axis    tvalid/tready/tdata/tuser       in         load symbol or advance command
//  m_axis    tvalid/tready/tdata/tlast/tuser out        one symbol of the new sequence
//  cfg       cfg_wr_en/cfg_index/cfg_data    in         seq_len, alphabet_size writes
//
//  A load writes one symbol to the sequence memory. An advance makes four passes
//  over the sequence memory (saturate, scan, refill, drain), the first, second
//  and last through its single read port, and walks the count memory twice
//  (search, refill).
//  The input is ready only while the sequencer is idle; the output register
//  lets the next transaction start while the final result still waits.
//  Reset is asynchronous; the count store is cleared by valid bits at the
//  start of every advance, so there is no clearing pass.
module multiset_next_permutation_top #(
    parameter int MAX_LEN     = 32,
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mnp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [3:0] symbol
    input  logic                                s_axis_tuser,  // [0] cmd
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mnp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [3:0] out_symbol, [8:4] position
    output logic                                m_axis_tlast,
    output logic                                m_axis_tuser,  // [0] exhausted
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [mnp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mnp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int LEN_CAP = (MAX_LEN < mnp_pkg::OUT_CAP) ? MAX_LEN : mnp_pkg::OUT_CAP;
    localparam int IW      = $clog2(LEN_CAP);        // sequence index
    localparam int LW      = $clog2(LEN_CAP + 1);    // sequence length
    localparam int CNT_W   = $clog2(LEN_CAP + 1);    // symbol count
    localparam int AW      = $clog2(MAX_LEN);        // sequence memory address
    localparam int CW      = $clog2(MAX_SYMBOLS);    // count memory address
    localparam int SW      = mnp_pkg::SYM_W;
    localparam int PW      = mnp_pkg::POS_W;
    localparam int ALW     = mnp_pkg::ALPHA_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SAT    = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_SEARCH = 3'd3;
    localparam logic [2:0] ST_FCHK   = 3'd4;
    localparam logic [2:0] ST_FWR    = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;
    localparam logic [2:0] ST_EXH    = 3'd7;

    // Control registers
    logic [2:0]                     state_reg, state_next;
    logic [IW-1:0]                  lp_reg, lp_next;
    logic [mnp_pkg::SEQ_LEN_W-1:0]  seq_len_reg, seq_len_next;
    logic [ALW-1:0]                 alpha_reg, alpha_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           em_rd_valid_reg, em_rd_valid_next;
    logic                           srch_pend_reg, srch_pend_next;
    logic [MAX_SYMBOLS-1:0]         cnt_vld_reg, cnt_vld_next;
    logic                           cnt_rvld_reg, cnt_rvld_next;

    // Payload registers
    logic [IW-1:0]  wr_idx_reg, wr_idx_next;
    logic [LW-1:0]  rd_idx_reg, rd_idx_next;
    logic [IW-1:0]  sc_idx_reg, sc_idx_next;
    logic [SW-1:0]  run_sym_reg, run_sym_next;
    logic [CNT_W-1:0] run_cnt_reg, run_cnt_next;
    logic [IW-1:0]  pivot_idx_reg, pivot_idx_next;
    logic [SW-1:0]  pivot_sym_reg, pivot_sym_next;
    logic [SW-1:0]  k_reg, k_next;
    logic [SW-1:0]  chk_reg, chk_next;
    logic [SW-1:0]  new_sym_reg, new_sym_next;
    logic [IW-1:0]  wpos_reg, wpos_next;
    logic [SW-1:0]  fill_sym_reg, fill_sym_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [LW-1:0]  em_idx_reg, em_idx_next;
    logic [IW-1:0]  rd_pos_reg, rd_pos_next;
    logic [SW-1:0]  out_sym_reg, out_sym_next;
    logic [PW-1:0]  out_pos_reg, out_pos_next;
    logic           out_last_reg, out_last_next;
    logic           out_exh_reg, out_exh_next;

    // Memory ports
    logic           seq_we, seq_re;
    logic [AW-1:0]  seq_waddr, seq_raddr;
    logic [SW-1:0]  seq_wdata, seq_rdata;
    logic           cnt_we, cnt_re;
    logic [CW-1:0]  cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0] cnt_wdata, cnt_rdata;

    // Derived values
    logic [LW-1:0]  len_eff, len_m1;
    logic [ALW-1:0] alpha_eff;
    logic [IW-1:0]  lp_cur;
    logic [LW-1:0]  lp_inc;
    logic [CNT_W-1:0] cnt_val, fill_cnt;
    logic           in_accept, out_accept, out_load;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;

    // Effective length and alphabet
    always_comb
    begin
        if (seq_len_reg < 6'd2)
            len_eff = LW'(2);
        else if (32'(seq_len_reg) > 32'(LEN_CAP))
            len_eff = LW'(LEN_CAP);
        else
            len_eff = LW'(seq_len_reg);

        if (alpha_reg == '0)
            alpha_eff = ALW'(1);
        else if (32'(alpha_reg) > 32'(MAX_SYMBOLS))
            alpha_eff = ALW'(MAX_SYMBOLS);
        else
            alpha_eff = alpha_reg;
    end

    assign len_m1 = len_eff - 1'b1;

    // Load pointer wrap
    assign lp_cur = (LW'(lp_reg) >= len_eff) ? '0 : lp_reg;
    assign lp_inc = LW'(lp_cur) + 1'b1;

    // Count read: entries not written this advance read as zero
    assign cnt_val  = cnt_rvld_reg ? cnt_rdata : '0;
    // Refill count: add back the old pivot, remove the new pivot symbol
    assign fill_cnt = cnt_val + CNT_W'(fill_sym_reg == pivot_sym_reg)
                              - CNT_W'(fill_sym_reg == new_sym_reg);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        lp_next          = lp_reg;
        seq_len_next     = seq_len_reg;
        alpha_next       = alpha_reg;
        out_valid_next   = out_valid_reg;
        em_rd_valid_next = em_rd_valid_reg;
        srch_pend_next   = srch_pend_reg;
        cnt_vld_next     = cnt_vld_reg;
        cnt_rvld_next    = cnt_rvld_reg;
        wr_idx_next      = wr_idx_reg;
        rd_idx_next      = rd_idx_reg;
        sc_idx_next      = sc_idx_reg;
        run_sym_next     = run_sym_reg;
        run_cnt_next     = run_cnt_reg;
        pivot_idx_next   = pivot_idx_reg;
        pivot_sym_next   = pivot_sym_reg;
        k_next           = k_reg;
        chk_next         = chk_reg;
        new_sym_next     = new_sym_reg;
        wpos_next        = wpos_reg;
        fill_sym_next    = fill_sym_reg;
        rem_next         = rem_reg;
        em_idx_next      = em_idx_reg;
        rd_pos_next      = rd_pos_reg;
        out_sym_next     = out_sym_reg;
        out_pos_next     = out_pos_reg;
        out_last_next    = out_last_reg;
        out_exh_next     = out_exh_reg;
        out_load         = 1'b0;

        seq_we    = 1'b0;
        seq_waddr = '0;
        seq_wdata = '0;
        seq_re    = 1'b0;
        seq_raddr = '0;
        cnt_we    = 1'b0;
        cnt_waddr = CW'(run_sym_reg);
        cnt_wdata = run_cnt_reg;
        cnt_re    = 1'b0;
        cnt_raddr = '0;

        // configuration writes
        if (cfg_wr_en)
        begin
            case (cfg_index)
                mnp_pkg::REG_SEQ_LEN:       seq_len_next = cfg_data;
                mnp_pkg::REG_ALPHABET_SIZE: alpha_next   = cfg_data[ALW-1:0];
                default:                    ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == mnp_pkg::CMD_LOAD)
                    begin
                        seq_we    = 1'b1;
                        seq_waddr = AW'(lp_cur);
                        seq_wdata = mnp_pkg::sat_sym(s_axis_tdata[SW-1:0], alpha_eff);
                        lp_next   = (lp_inc >= len_eff) ? '0 : IW'(lp_inc);
                    end
                    else
                    begin
                        // start the saturation pass at position 0
                        cnt_vld_next = '0;
                        seq_re       = 1'b1;
                        seq_raddr    = '0;
                        wr_idx_next  = '0;
                        rd_idx_next  = LW'(1);
                        state_next   = ST_SAT;
                    end
                end
            end

            ST_SAT:
            begin
                // write back the saturated symbol read last cycle
                seq_we    = 1'b1;
                seq_waddr = AW'(wr_idx_reg);
                seq_wdata = mnp_pkg::sat_sym(seq_rdata, alpha_eff);
                if (rd_idx_reg == len_eff)
                begin
                    // last position seeds the right-to-left scan
                    run_sym_next = mnp_pkg::sat_sym(seq_rdata, alpha_eff);
                    run_cnt_next = CNT_W'(1);
                    seq_re       = 1'b1;
                    seq_raddr    = AW'(len_eff - LW'(2));
                    sc_idx_next  = IW'(len_eff - LW'(2));
                    state_next   = ST_SCAN;
                end
                else
                begin
                    seq_re      = 1'b1;
                    seq_raddr   = AW'(rd_idx_reg);
                    wr_idx_next = IW'(rd_idx_reg);
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end

            ST_SCAN:
            begin
                // suffix is non-increasing, so equal symbols form one run
                if (seq_rdata < run_sym_reg)
                begin
                    cnt_we         = 1'b1;
                    cnt_vld_next[CW'(run_sym_reg)] = 1'b1;
                    pivot_idx_next = sc_idx_reg;
                    pivot_sym_next = seq_rdata;
                    k_next         = seq_rdata + 1'b1;
                    srch_pend_next = 1'b0;
                    state_next     = ST_SEARCH;
                end
                else
                begin
                    if (seq_rdata == run_sym_reg)
                    begin
                        run_cnt_next = run_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        cnt_we       = 1'b1;
                        cnt_vld_next[CW'(run_sym_reg)] = 1'b1;
                        run_sym_next = seq_rdata;
                        run_cnt_next = CNT_W'(1);
                    end
                    if (sc_idx_reg == '0)
                    begin
                        state_next = ST_EXH;
                    end
                    else
                    begin
                        seq_re      = 1'b1;
                        seq_raddr   = AW'(sc_idx_reg - 1'b1);
                        sc_idx_next = sc_idx_reg - 1'b1;
                    end
                end
            end

            ST_SEARCH:
            begin
                // smallest present symbol above the pivot, bounded by the alphabet
                if (srch_pend_reg &&
                    (cnt_val != '0 || ALW'(chk_reg) == alpha_eff - 1'b1))
                begin
                    new_sym_next  = chk_reg;
                    seq_we        = 1'b1;
                    seq_waddr     = AW'(pivot_idx_reg);
                    seq_wdata     = chk_reg;
                    wpos_next     = pivot_idx_reg + 1'b1;
                    fill_sym_next = '0;
                    cnt_re        = 1'b1;
                    cnt_raddr     = '0;
                    state_next    = ST_FCHK;
                end
                else
                begin
                    cnt_re         = 1'b1;
                    cnt_raddr      = CW'(k_reg);
                    chk_next       = k_reg;
                    k_next         = k_reg + 1'b1;
                    srch_pend_next = 1'b1;
                end
            end

            ST_FCHK:
            begin
                if (fill_cnt == '0)
                begin
                    fill_sym_next = fill_sym_reg + 1'b1;
                    cnt_re        = 1'b1;
                    cnt_raddr     = CW'(fill_sym_reg + 1'b1);
                end
                else
                begin
                    rem_next   = fill_cnt;
                    state_next = ST_FWR;
                end
            end

            ST_FWR:
            begin
                // refill the suffix in ascending order
                seq_we    = 1'b1;
                seq_waddr = AW'(wpos_reg);
                seq_wdata = fill_sym_reg;
                wpos_next = wpos_reg + 1'b1;
                rem_next  = rem_reg - 1'b1;
                if (LW'(wpos_reg) == len_m1)
                begin
                    seq_re           = 1'b1;
                    seq_raddr        = '0;
                    em_idx_next      = LW'(1);
                    rd_pos_next      = '0;
                    em_rd_valid_next = 1'b1;
                    state_next       = ST_EMIT;
                end
                else if (rem_reg == CNT_W'(1))
                begin
                    fill_sym_next = fill_sym_reg + 1'b1;
                    cnt_re        = 1'b1;
                    cnt_raddr     = CW'(fill_sym_reg + 1'b1);
                    state_next    = ST_FCHK;
                end
            end

            ST_EMIT:
            begin
                // memory read data acts as the stage in front of the output register
                out_load = em_rd_valid_reg && (!out_valid_reg || out_accept);
                if (out_load)
                begin
                    out_sym_next  = seq_rdata;
                    out_pos_next  = PW'(rd_pos_reg);
                    out_last_next = (LW'(rd_pos_reg) == len_m1);
                    out_exh_next  = 1'b0;
                end
                if (em_idx_reg < len_eff && (!em_rd_valid_reg || out_load))
                begin
                    seq_re           = 1'b1;
                    seq_raddr        = AW'(em_idx_reg);
                    rd_pos_next      = IW'(em_idx_reg);
                    em_idx_next      = em_idx_reg + 1'b1;
                    em_rd_valid_next = 1'b1;
                end
                else if (out_load)
                begin
                    em_rd_valid_next = 1'b0;
                end
                if (out_load && LW'(rd_pos_reg) == len_m1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_EXH:
            begin
                if (!out_valid_reg || out_accept)
                begin
                    out_load      = 1'b1;
                    out_sym_next  = '0;
                    out_pos_next  = '0;
                    out_last_next = 1'b1;
                    out_exh_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // output register occupancy
        if (out_accept)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end

        // track whether the count read data comes from a written entry
        if (cnt_re)
        begin
            cnt_rvld_next = cnt_vld_reg[cnt_raddr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            lp_reg          <= '0;
            seq_len_reg     <= mnp_pkg::SEQ_LEN_RST;
            alpha_reg       <= mnp_pkg::ALPHA_RST;
            out_valid_reg   <= 1'b0;
            em_rd_valid_reg <= 1'b0;
            srch_pend_reg   <= 1'b0;
            cnt_vld_reg     <= '0;
            cnt_rvld_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            lp_reg          <= lp_next;
            seq_len_reg     <= seq_len_next;
            alpha_reg       <= alpha_next;
            out_valid_reg   <= out_valid_next;
            em_rd_valid_reg <= em_rd_valid_next;
            srch_pend_reg   <= srch_pend_next;
            cnt_vld_reg     <= cnt_vld_next;
            cnt_rvld_reg    <= cnt_rvld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wr_idx_reg    <= wr_idx_next;
        rd_idx_reg    <= rd_idx_next;
        sc_idx_reg    <= sc_idx_next;
        run_sym_reg   <= run_sym_next;
        run_cnt_reg   <= run_cnt_next;
        pivot_idx_reg <= pivot_idx_next;
        pivot_sym_reg <= pivot_sym_next;
        k_reg         <= k_next;
        chk_reg       <= chk_next;
        new_sym_reg   <= new_sym_next;
        wpos_reg      <= wpos_next;
        fill_sym_reg  <= fill_sym_next;
        rem_reg       <= rem_next;
        em_idx_reg    <= em_idx_next;
        rd_pos_reg    <= rd_pos_next;
        out_sym_reg   <= out_sym_next;
        out_pos_reg   <= out_pos_next;
        out_last_reg  <= out_last_next;
        out_exh_reg   <= out_exh_next;
    end

    // Sequence store
    mnp_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_LEN)
    ) u_seq_ram (
        .clk     (clk),
        .wr_en   (seq_we),
        .wr_addr (seq_waddr),
        .wr_data (seq_wdata),
        .rd_en   (seq_re),
        .rd_addr (seq_raddr),
        .rd_data (seq_rdata)
    );

    // Symbol count store
    mnp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_SYMBOLS)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_en   (cnt_re),
        .rd_addr (cnt_raddr),
        .rd_data (cnt_rdata)
    );

    // Ports
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(mnp_pkg::OUT_TDATA_W - PW - SW){1'b0}}, out_pos_reg, out_sym_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_exh_reg;

`ifndef ASSERT_OFF
    // An exhausted result is a lone all-zero final transaction
    a_exh_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && out_sym_reg == '0 &&
                                             out_pos_reg == '0))
        else $error("exhausted result malformed");

    // No fetched symbol may be left behind when the sequencer goes idle
    a_no_stale_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !em_rd_valid_reg)
        else $error("emit read data dropped");

    // Within a run the next position follows immediately after a transaction
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && !m_axis_tlast) |=>
            (m_axis_tvalid && out_pos_reg == $past(out_pos_reg) + 1'b1))
        else $error("position gap in emitted run");
`endif

endmodule

[test/multiset_next_permutation_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for multiset_next_permutation_top: directed and random load/advance
// traffic with bursty input and stalling output, checked against an in-bench successor predictor.
// Depends on mnp_pkg and the RTL of multiset_next_permutation_top.
module multiset_next_permutation_top_tb;
    import mnp_pkg::*;

    localparam int MAX_LEN      = 32;
    localparam int MAX_SYMBOLS  = 16;
    localparam int TOTAL_ITEMS  = 310;
    localparam int DRAIN_CYCLES = 200;   // extra wait in settle after the last expected result
    localparam int IDLE_LIMIT   = 5000;  // cycles with no transaction before giving up
    localparam int MAX_REPORTS  = 10;

    // One symbol of an emitted permutation, or the exhausted marker
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [POS_W-1:0] pos;
        logic             last;
        logic             exhausted;
    } perm_result_t;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [3:0] symbol
    logic                   s_axis_tuser  = CMD_LOAD;  // [0] cmd
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [3:0] out_symbol, [8:4] position
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;         // [0] exhausted
    logic                   cfg_wr_en     = 1'b0;
    cfg_idx_t               cfg_index     = REG_SEQ_LEN;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    // Predictor state
    logic [SYM_W-1:0]     perm_seq [MAX_LEN];
    bit                   pos_written [MAX_LEN];
    int unsigned          load_ptr;
    logic [SEQ_LEN_W-1:0] len_reg;
    logic [ALPHA_W-1:0]   alpha_reg;
    perm_result_t         expected_perm_q[$];

    // Checker and traffic bookkeeping
    int           error_count = 0;
    int           items_sent  = 0;
    int           burst_left  = 0;
    int           idle_cycles = 0;
    perm_result_t seen_result;
    perm_result_t want_result;

    multiset_next_permutation_top #(
        .MAX_LEN     (MAX_LEN),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int active_len();
        int l;
        l = len_reg;
        if (l < 2) l = 2;
        if (l > MAX_LEN) l = MAX_LEN;
        return l;
    endfunction

    function automatic int active_alpha();
        int a;
        a = alpha_reg;
        if (a < 1) a = 1;
        if (a > MAX_SYMBOLS) a = MAX_SYMBOLS;
        return a;
    endfunction

    function automatic logic [SYM_W-1:0] clip_symbol(input int s, input int alpha);
        return (s >= alpha) ? SYM_W'(alpha - 1) : SYM_W'(s);
    endfunction

    // An advance may only read positions that were loaded since reset
    function automatic bit sequence_complete();
        bit ok;
        ok = 1'b1;
        for (int i = 0; i < active_len(); i++)
            if (!pos_written[i]) ok = 1'b0;
        return ok;
    endfunction

    task automatic apply_load(input logic [SYM_W-1:0] s);
        int len;
        len = active_len();
        if (load_ptr >= len) load_ptr = 0;
        perm_seq[load_ptr]    = clip_symbol(s, active_alpha());
        pos_written[load_ptr] = 1'b1;
        load_ptr++;
        if (load_ptr >= len) load_ptr = 0;
    endtask

    // Step the sequence to its successor and queue the symbols it emits
    task automatic predict_successor();
        int           len;
        int           alpha;
        int           pivot;
        int           k;
        int           wr;
        int           tally [MAX_SYMBOLS];
        perm_result_t r;
        len   = active_len();
        alpha = active_alpha();
        pivot = -1;
        for (int i = 0; i < len; i++)
            perm_seq[i] = clip_symbol(perm_seq[i], alpha);
        foreach (tally[i]) tally[i] = 0;

        // scan from the right, counting the non-increasing suffix
        tally[perm_seq[len-1]]++;
        for (int i = len - 1; i > 0 && pivot < 0; i--)
        begin
            if (perm_seq[i-1] < perm_seq[i])
                pivot = i - 1;
            else
                tally[perm_seq[i-1]]++;
        end

        if (pivot < 0)
        begin
            r = '{sym: '0, pos: '0, last: 1'b1, exhausted: 1'b1};
            expected_perm_q.push_back(r);
        end
        else
        begin
            // next larger symbol present in the suffix replaces the pivot
            tally[perm_seq[pivot]]++;
            k = perm_seq[pivot] + 1;
            while (k + 1 < alpha && tally[k] == 0) k++;
            tally[k]--;
            perm_seq[pivot] = SYM_W'(k);
            // refill the suffix in ascending order
            wr = pivot + 1;
            for (int s = 0; s < alpha; s++)
                for (int c = 0; c < tally[s] && wr < len; c++)
                begin
                    perm_seq[wr] = SYM_W'(s);
                    wr++;
                end
            for (int i = 0; i < len; i++)
            begin
                r = '{sym: perm_seq[i], pos: POS_W'(i), last: (i == len - 1), exhausted: 1'b0};
                expected_perm_q.push_back(r);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Drive one transaction in bursts with random gaps, then update the predictor
    task automatic send_item(input logic cmd, input logic [SYM_W-1:0] sym);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(sym);
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        burst_left--;
        items_sent++;
        if (cmd == CMD_LOAD)
            apply_load(sym);
        else
            predict_successor();
    endtask

    // Bring the block to idle: all results in and the last advance finished
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_perm_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both registers on back-to-back cycles; call only when idle
    task automatic set_config(input logic [CFG_DATA_W-1:0] len_val,
                              input logic [CFG_DATA_W-1:0] alpha_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SEQ_LEN;
        cfg_data  <= len_val;
        @(posedge clk);
        len_reg   = len_val;
        cfg_index <= REG_ALPHABET_SIZE;
        cfg_data  <= alpha_val;
        @(posedge clk);
        alpha_reg = alpha_val[ALPHA_W-1:0];
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_full_sequence(input bit in_range);
        repeat (active_len())
        begin
            if (in_range)
                send_item(CMD_LOAD, SYM_W'($urandom_range(0, active_alpha() - 1)));
            else
                send_item(CMD_LOAD, SYM_W'($urandom_range(0, 15)));
        end
    endtask

    task automatic advance_burst(input int n);
        repeat (n)
            if (sequence_complete())
                send_item(CMD_ADVANCE, SYM_W'($urandom_range(0, 15)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: length 2, full alphabet; swap then run out of successors
    task automatic test_reset_defaults();
        send_item(CMD_LOAD, 4'd3);
        send_item(CMD_LOAD, 4'd9);
        send_item(CMD_ADVANCE, 4'd0);
        send_item(CMD_ADVANCE, 4'd15);
        send_item(CMD_LOAD, 4'd15);
        send_item(CMD_LOAD, 4'd0);
        send_item(CMD_ADVANCE, 4'd0);
    endtask

    // Register values below range clamp to length 2 and a one-symbol alphabet
    task automatic test_low_clamp();
        settle();
        set_config(6'd0, 6'd0);
        send_item(CMD_LOAD, 4'd15);
        send_item(CMD_LOAD, 4'd5);
        send_item(CMD_ADVANCE, 4'd0);
    endtask

    // Stored symbols above a shrunk alphabet saturate when the advance reads them
    task automatic test_alphabet_shrink();
        settle();
        set_config(6'd3, 6'd16);
        send_item(CMD_LOAD, 4'd10);
        send_item(CMD_LOAD, 4'd2);
        send_item(CMD_LOAD, 4'd12);
        settle();
        set_config(6'd3, 6'd5);
        send_item(CMD_ADVANCE, 4'd0);
        settle();
        set_config(6'd1, 6'd31);
        send_item(CMD_ADVANCE, 4'd0);
    endtask

    // Load pointer past the new length restarts at position 0
    task automatic test_pointer_restart();
        settle();
        set_config(6'd4, 6'd16);
        send_item(CMD_LOAD, 4'd1);
        send_item(CMD_LOAD, 4'd2);
        send_item(CMD_LOAD, 4'd3);
        settle();
        set_config(6'd2, 6'd16);
        send_item(CMD_LOAD, 4'd0);
        send_item(CMD_ADVANCE, 4'd0);
    endtask

    // Length above range clamps to the full 32 positions
    task automatic test_longest_sequence();
        settle();
        set_config(6'd63, 6'd16);
        load_full_sequence(1'b0);
        advance_burst(4);
        settle();
        set_config(6'd32, 6'd3);
        load_full_sequence(1'b1);
        advance_burst(3);
    endtask

    // Random settings; mostly full loads followed by runs of advances
    task automatic test_random_traffic();
        int sel;
        int start;
        int target;
        logic [CFG_DATA_W-1:0] len_val;
        logic [CFG_DATA_W-1:0] alpha_val;
        while (items_sent < TOTAL_ITEMS)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 14)      len_val = $urandom_range(2, 8);
            else if (sel < 17) len_val = $urandom_range(9, 32);
            else if (sel < 18) len_val = $urandom_range(0, 1);
            else               len_val = $urandom_range(33, 63);
            sel = $urandom_range(0, 19);
            if (sel < 12)      alpha_val = $urandom_range(1, 6);
            else if (sel < 16) alpha_val = $urandom_range(7, 16);
            else if (sel < 17) alpha_val = 6'd0;
            else               alpha_val = $urandom_range(17, 63);
            settle();
            set_config(len_val, alpha_val);

            start  = items_sent;
            target = $urandom_range(25, 60);
            while (items_sent - start < target && items_sent < TOTAL_ITEMS)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 6)
                begin
                    load_full_sequence($urandom_range(0, 3) != 0);
                    advance_burst($urandom_range(1, 6));
                end
                else if (sel < 8 && sequence_complete())
                    advance_burst($urandom_range(1, 3));
                else
                begin
                    // stray loads that leave the sequence partly rewritten
                    repeat ($urandom_range(1, 3))
                        send_item(CMD_LOAD, SYM_W'($urandom_range(0, 15)));
                    advance_burst(1);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern and result checker
    // ------------------------------------------------------------------

    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        else
            stall_left--;
        case (stall_mode)
            2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            3:       m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_result = '{sym: m_axis_tdata[3:0], pos: m_axis_tdata[8:4],
                            last: m_axis_tlast, exhausted: m_axis_tuser};
            if (expected_perm_q.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: sym %0d pos %0d last %0b exhausted %0b",
                             seen_result.sym, seen_result.pos, seen_result.last,
                             seen_result.exhausted);
            end
            else
            begin
                want_result = expected_perm_q.pop_front();
                if (seen_result.sym !== want_result.sym || seen_result.pos !== want_result.pos ||
                    seen_result.last !== want_result.last ||
                    seen_result.exhausted !== want_result.exhausted)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"result mismatch: expected sym %0d pos %0d last %0b ",
                                  "exhausted %0b, got sym %0d pos %0d last %0b exhausted %0b"},
                                 want_result.sym, want_result.pos, want_result.last,
                                 want_result.exhausted, seen_result.sym, seen_result.pos,
                                 seen_result.last, seen_result.exhausted);
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either stream
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("multiset_next_permutation_top_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------

    initial
    begin
        foreach (perm_seq[i])
        begin
            perm_seq[i]    = '0;
            pos_written[i] = 1'b0;
        end
        load_ptr  = 0;
        len_reg   = SEQ_LEN_RST;
        alpha_reg = ALPHA_RST;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_low_clamp();
        test_alphabet_shrink();
        test_pointer_restart();
        test_longest_sequence();
        test_random_traffic();

        settle();
        error_count += expected_perm_q.size();
        if (error_count == 0)
            $display("multiset_next_permutation_top_tb: clean");
        else
            $display("multiset_next_permutation_top_tb: errors");
        $finish;
    end

endmodule

[sim.f]
rtl/mnp_pkg.sv
rtl/mnp_ram.sv
rtl/multiset_next_permutation_top.sv
test/multiset_next_permutation_top_tb.sv
